// ----- sv/ijs_pkg.sv -----
package ijs_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COUNT_W = 16;
  localparam int TSUM_W = 40;
  localparam int TSQ_W = 64;
  localparam int FIXED_W = 28;

  // shared divide / square root unit
  localparam int OPND_W = 72;
  localparam int REM_W = 36;
  localparam int RES_W = 64;
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] MEAN_STEPS = 7'd44;
  localparam logic [STEP_W-1:0] VAR_STEPS = 7'd72;
  localparam logic [STEP_W-1:0] ROOT_STEPS = 7'd32;

  localparam logic REPORT_BATCH = 1'b0;
  localparam logic REPORT_TOTAL = 1'b1;

  typedef enum logic {
    CALC_DIV,
    CALC_SQRT
  } calc_mode_t;

  typedef struct packed {
    calc_mode_t mode;
    logic [STEP_W-1:0] steps;
    logic [OPND_W-1:0] operand;
    logic [COUNT_W-1:0] divisor;
  } calc_cmd_t;

  typedef struct packed {
    logic diff;
    logic square;
    logic acc;
    logic merge;
    logic clear_batch;
    logic clear_total;
  } stats_ctl_t;

  // one set of statistics selected for a report
  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic [SAMPLE_W-1:0] mn;
    logic [SAMPLE_W-1:0] mx;
    logic [TSUM_W-1:0] sum;
    logic [TSQ_W-1:0] sq;
  } stat_set_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_ACC,
    ST_CLOSE,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_VAR,
    ST_VAR_WAIT,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_OUT,
    ST_FIN
  } state_t;

endpackage

// ----- sv/ijs_calc.sv -----
module ijs_calc (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  ijs_pkg::calc_cmd_t            cmd,
  output logic                          busy,
  output logic                          done,
  output logic [ijs_pkg::RES_W-1:0]     res
);

  logic [ijs_pkg::OPND_W-1:0] opnd;
  logic [ijs_pkg::REM_W-1:0] rem;
  logic [ijs_pkg::STEP_W-1:0] cnt;
  ijs_pkg::calc_mode_t mode;
  logic [ijs_pkg::COUNT_W-1:0] divisor;

  logic [ijs_pkg::REM_W-1:0] rem_sh;
  logic [ijs_pkg::REM_W-1:0] trial;
  logic [ijs_pkg::REM_W-1:0] rem_sub;
  logic ge;

  // one compare and subtract per cycle: a quotient bit or a root bit
  always_comb begin
    if (mode == ijs_pkg::CALC_SQRT) begin
      rem_sh = {rem[ijs_pkg::REM_W-3:0], opnd[ijs_pkg::OPND_W-1 -: 2]};
      trial = {res[ijs_pkg::REM_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem[ijs_pkg::REM_W-2:0], opnd[ijs_pkg::OPND_W-1]};
      trial = ijs_pkg::REM_W'(divisor);
    end
    ge = rem_sh >= trial;
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= cmd.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ijs_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= cmd.operand;
      rem <= '0;
      res <= '0;
      mode <= cmd.mode;
      divisor <= cmd.divisor;
    end else if (busy) begin
      if (mode == ijs_pkg::CALC_SQRT) begin
        opnd <= {opnd[ijs_pkg::OPND_W-3:0], 2'b00};
      end else begin
        opnd <= {opnd[ijs_pkg::OPND_W-2:0], 1'b0};
      end
      rem <= ge ? rem_sub : rem_sh;
      res <= {res[ijs_pkg::RES_W-2:0], ge};
    end
  end

endmodule

// ----- sv/ijs_stats.sv -----
module ijs_stats #(
  parameter int BATCH_MAX = 2048,
  parameter int TOTAL_MAX = 65535
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ijs_pkg::stats_ctl_t              ctl,
  input  logic                             has,
  input  logic [ijs_pkg::SAMPLE_W-1:0]     v,
  input  logic [ijs_pkg::SAMPLE_W-1:0]     nom,
  input  logic                             sel_total,
  output logic                             batch_nonempty,
  output logic                             total_nonempty,
  output ijs_pkg::stat_set_t               set
);

  localparam int CNT_W = $clog2(BATCH_MAX + 1);
  localparam int BSUM_W = ijs_pkg::SAMPLE_W + CNT_W;
  localparam int BSQ_W = 2 * ijs_pkg::SAMPLE_W + CNT_W;
  localparam int SQ_W = 2 * ijs_pkg::SAMPLE_W;

  logic [ijs_pkg::SAMPLE_W-1:0] d;
  logic [SQ_W-1:0] dsq;

  logic [CNT_W-1:0] batch_count;
  logic [ijs_pkg::SAMPLE_W-1:0] batch_min;
  logic [ijs_pkg::SAMPLE_W-1:0] batch_max;
  logic [BSUM_W-1:0] batch_sum;
  logic [BSQ_W-1:0] batch_square_sum;

  logic [ijs_pkg::COUNT_W-1:0] total_count;
  logic [ijs_pkg::SAMPLE_W-1:0] total_min;
  logic [ijs_pkg::SAMPLE_W-1:0] total_max;
  logic [ijs_pkg::TSUM_W-1:0] total_sum;
  logic [ijs_pkg::TSQ_W-1:0] total_square_sum;

  logic [ijs_pkg::COUNT_W:0] merged_count;
  logic fits;

  assign merged_count = {1'b0, total_count} + (ijs_pkg::COUNT_W + 1)'(batch_count);
  assign fits = merged_count <= (ijs_pkg::COUNT_W + 1)'(TOTAL_MAX);

  // deviation from nominal, then its square, one register each
  always_ff @(posedge clk) begin
    if (ctl.diff) begin
      d <= (v >= nom) ? v - nom : nom - v;
    end
    if (ctl.square) begin
      dsq <= SQ_W'(d) * SQ_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_batch) begin
      batch_count <= '0;
      batch_min <= '1;
      batch_max <= '0;
      batch_sum <= '0;
      batch_square_sum <= '0;
    end else if (ctl.acc && has && (batch_count < CNT_W'(BATCH_MAX))) begin
      batch_count <= batch_count + 1'b1;
      if (v < batch_min) begin
        batch_min <= v;
      end
      if (v > batch_max) begin
        batch_max <= v;
      end
      batch_sum <= batch_sum + BSUM_W'(v);
      batch_square_sum <= batch_square_sum + BSQ_W'(dsq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_total) begin
      total_count <= '0;
      total_min <= '1;
      total_max <= '0;
      total_sum <= '0;
      total_square_sum <= '0;
    end else if (ctl.merge && fits) begin
      total_count <= merged_count[ijs_pkg::COUNT_W-1:0];
      if (batch_min < total_min) begin
        total_min <= batch_min;
      end
      if (batch_max > total_max) begin
        total_max <= batch_max;
      end
      total_sum <= total_sum + ijs_pkg::TSUM_W'(batch_sum);
      total_square_sum <= total_square_sum + ijs_pkg::TSQ_W'(batch_square_sum);
    end
  end

  assign batch_nonempty = batch_count != '0;
  assign total_nonempty = total_count != '0;

  always_comb begin
    if (sel_total) begin
      set.cnt = total_count;
      set.mn = total_min;
      set.mx = total_max;
      set.sum = total_sum;
      set.sq = total_square_sum;
    end else begin
      set.cnt = ijs_pkg::COUNT_W'(batch_count);
      set.mn = batch_min;
      set.mx = batch_max;
      set.sum = ijs_pkg::TSUM_W'(batch_sum);
      set.sq = ijs_pkg::TSQ_W'(batch_square_sum);
    end
  end

endmodule

// ----- sv/interval_jitter_statistics_top.sv -----
// Interval jitter statistics. Each input transaction carries at most one
// interval sample and may close the current batch (end_of_batch or
// final_req); final_req also reports and clears the running totals. A new
// transaction is taken only after the previous one and its reports are
// finished. Each report (batch or total) can stall on out_ready. One shared
// compare/subtract unit retires one bit per cycle for the mean (44 steps),
// for the scaled mean square deviation (72 steps) and for its square root
// (32 steps). A transaction is taken only while in_ready is high, and a
// report stays on the output until out_ready; last marks the final report
// of a transaction.
module interval_jitter_statistics_top #(
  parameter int BATCH_MAX = 2048,
  parameter int TOTAL_MAX = 65535,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               nominal_period_we,
  input  logic [ijs_pkg::SAMPLE_W-1:0]       nominal_period,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               has_sample,
  input  logic [ijs_pkg::SAMPLE_W-1:0]       interval_us,
  input  logic                               end_of_batch,
  input  logic                               final_req,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               report_kind,
  output logic [ijs_pkg::COUNT_W-1:0]        sample_count,
  output logic [ijs_pkg::FIXED_W-1:0]        mean_q4,
  output logic [ijs_pkg::FIXED_W-1:0]        deviation_q4,
  output logic [ijs_pkg::SAMPLE_W-1:0]       min_interval,
  output logic [ijs_pkg::SAMPLE_W-1:0]       max_interval,
  output logic                               last
);

  localparam int SAT_BITS =
      (SAMPLE_BITS < ijs_pkg::SAMPLE_W) ? SAMPLE_BITS : ijs_pkg::SAMPLE_W;
  localparam logic [ijs_pkg::SAMPLE_W-1:0] SAT_LIMIT =
      ijs_pkg::SAMPLE_W'((64'(1) << SAT_BITS) - 64'(1));

  ijs_pkg::state_t state;
  ijs_pkg::state_t state_next;

  logic [ijs_pkg::SAMPLE_W-1:0] nom_period;
  logic has_r;
  logic [ijs_pkg::SAMPLE_W-1:0] v_r;
  logic close_r;
  logic fin_r;
  logic src_total;
  logic src_total_next;
  logic [ijs_pkg::FIXED_W-1:0] mean_r;

  ijs_pkg::stats_ctl_t ctl;
  ijs_pkg::stat_set_t set;
  logic batch_nonempty;
  logic total_nonempty;

  ijs_pkg::calc_cmd_t calc_cmd;
  logic calc_start;
  logic calc_busy;
  logic calc_done;
  logic [ijs_pkg::RES_W-1:0] calc_res;

  logic accept;
  logic load_out;
  logic out_clear;

  assign accept = in_valid && in_ready;

  ijs_stats #(
    .BATCH_MAX(BATCH_MAX),
    .TOTAL_MAX(TOTAL_MAX)
  ) u_stats (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .has(has_r),
    .v(v_r),
    .nom(nom_period),
    .sel_total(src_total),
    .batch_nonempty(batch_nonempty),
    .total_nonempty(total_nonempty),
    .set(set)
  );

  ijs_calc u_calc (
    .clk(clk),
    .rst(rst),
    .start(calc_start),
    .cmd(calc_cmd),
    .busy(calc_busy),
    .done(calc_done),
    .res(calc_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nom_period <= ijs_pkg::SAMPLE_W'(1000);
    end else if (nominal_period_we) begin
      nom_period <= nominal_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ijs_pkg::ST_IDLE;
      out_valid <= 1'b0;
      src_total <= 1'b0;
    end else begin
      state <= state_next;
      src_total <= src_total_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_clear) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      has_r <= has_sample;
      v_r <= (interval_us > SAT_LIMIT) ? SAT_LIMIT : interval_us;
      close_r <= end_of_batch || final_req;
      fin_r <= final_req;
    end
    if (state == ijs_pkg::ST_MEAN_WAIT && calc_done) begin
      mean_r <= calc_res[ijs_pkg::FIXED_W-1:0];
    end
    if (load_out) begin
      report_kind <= src_total;
      sample_count <= set.cnt;
      mean_q4 <= mean_r;
      deviation_q4 <= calc_res[ijs_pkg::FIXED_W-1:0];
      min_interval <= set.mn;
      max_interval <= set.mx;
      // a batch report is last unless a total report follows
      last <= src_total || !(fin_r && total_nonempty);
    end
  end

  always_comb begin
    state_next = state;
    src_total_next = src_total;
    in_ready = 1'b0;
    ctl = '0;
    calc_start = 1'b0;
    calc_cmd.mode = ijs_pkg::CALC_DIV;
    calc_cmd.steps = ijs_pkg::MEAN_STEPS;
    calc_cmd.operand = {set.sum, 4'b0, {(ijs_pkg::OPND_W - ijs_pkg::TSUM_W - 4){1'b0}}};
    calc_cmd.divisor = set.cnt;
    load_out = 1'b0;
    out_clear = 1'b0;
    unique case (state)
      ijs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ijs_pkg::ST_DIFF;
        end
      end
      ijs_pkg::ST_DIFF: begin
        ctl.diff = 1'b1;
        state_next = ijs_pkg::ST_SQUARE;
      end
      ijs_pkg::ST_SQUARE: begin
        ctl.square = 1'b1;
        state_next = ijs_pkg::ST_ACC;
      end
      ijs_pkg::ST_ACC: begin
        ctl.acc = 1'b1;
        state_next = close_r ? ijs_pkg::ST_CLOSE : ijs_pkg::ST_IDLE;
      end
      ijs_pkg::ST_CLOSE: begin
        // totals take the batch now if the merged count stays within TOTAL_MAX; the batch itself is reported first
        if (batch_nonempty) begin
          ctl.merge = 1'b1;
          src_total_next = ijs_pkg::REPORT_BATCH;
          state_next = ijs_pkg::ST_MEAN;
        end else begin
          ctl.clear_batch = 1'b1;
          state_next = ijs_pkg::ST_FIN;
        end
      end
      ijs_pkg::ST_MEAN: begin
        calc_start = 1'b1;
        state_next = ijs_pkg::ST_MEAN_WAIT;
      end
      ijs_pkg::ST_MEAN_WAIT: begin
        if (calc_done) begin
          state_next = ijs_pkg::ST_VAR;
        end
      end
      ijs_pkg::ST_VAR: begin
        // 256 * square_sum / count, low 64 bits of the quotient
        calc_start = 1'b1;
        calc_cmd.steps = ijs_pkg::VAR_STEPS;
        calc_cmd.operand = {set.sq, 8'b0};
        state_next = ijs_pkg::ST_VAR_WAIT;
      end
      ijs_pkg::ST_VAR_WAIT: begin
        if (calc_done) begin
          state_next = ijs_pkg::ST_ROOT;
        end
      end
      ijs_pkg::ST_ROOT: begin
        calc_start = 1'b1;
        calc_cmd.mode = ijs_pkg::CALC_SQRT;
        calc_cmd.steps = ijs_pkg::ROOT_STEPS;
        calc_cmd.operand = {calc_res, 8'b0};
        state_next = ijs_pkg::ST_ROOT_WAIT;
      end
      ijs_pkg::ST_ROOT_WAIT: begin
        if (calc_done) begin
          load_out = 1'b1;
          state_next = ijs_pkg::ST_OUT;
        end
      end
      ijs_pkg::ST_OUT: begin
        if (out_ready) begin
          out_clear = 1'b1;
          if (src_total) begin
            ctl.clear_total = 1'b1;
            state_next = ijs_pkg::ST_IDLE;
          end else begin
            ctl.clear_batch = 1'b1;
            state_next = ijs_pkg::ST_FIN;
          end
        end
      end
      ijs_pkg::ST_FIN: begin
        if (fin_r && total_nonempty) begin
          src_total_next = ijs_pkg::REPORT_TOTAL;
          state_next = ijs_pkg::ST_MEAN;
        end else begin
          ctl.clear_total = fin_r;
          state_next = ijs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ijs_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_out_only_in_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ijs_pkg::ST_OUT))
    else $error("report shown outside the output state");

  a_done_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    calc_done |-> (state == ijs_pkg::ST_MEAN_WAIT || state == ijs_pkg::ST_VAR_WAIT ||
                   state == ijs_pkg::ST_ROOT_WAIT))
    else $error("calculation finished while no step waited for it");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    calc_start |-> !calc_busy)
    else $error("calculation started while the unit was busy");

  a_total_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && report_kind) |-> last)
    else $error("total report not marked last");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("loaded report not presented");
`endif

endmodule
